[design/assert_macros.svh]
// Assertion macros shared by the scheduler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

[design/pps_pkg.sv]
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;
  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS = 16;
  localparam logic MODE_ARRIVAL = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [7:0]  task_id;
    logic [15:0] burst;
    logic [7:0]  priority_req;
  } in_item_t;

  typedef struct packed {
    logic        dropped;
    logic        ran_valid;
    logic [7:0]  ran_id;
    logic        finished;
    logic [15:0] completion_time;
    logic [15:0] turnaround;
    logic [15:0] waiting;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic arrive;
    logic scan_start;
    logic scan_step;
    logic shift_step;
    logic decide;
    logic push_back;
    logic finish_tick;
  } ctrl_t;

  typedef struct packed {
    logic mode;
    logic arrive_ok;
    logic queue_empty;
    logic scan_done;
    logic take;
    logic preempt;
    logic shift_done;
  } stat_t;
endpackage

[design/preemptive_priority_scheduler_core.sv]
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_core
// Preemptive priority scheduler with a sixteen-entry ready queue.
// ----------------------------------------------------------------------------
// One item at a time: the next item is accepted only after the result of the
// previous one has been taken. A tick scans the queue memory one entry a cycle,
// then closes the gap behind a dispatched entry one entry a cycle, pushes a
// preempted task back and runs the slot. With an empty queue a tick only runs
// the slot. The queue memory has a single read port.
module preemptive_priority_scheduler_core #(
  parameter int QUEUE_DEPTH = pps_pkg::QUEUE_DEPTH,
  parameter int TIME_BITS = pps_pkg::TIME_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pps_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pps_pkg::out_item_t out_data
);
  pps_pkg::ctrl_t ctrl;
  pps_pkg::stat_t stat;

  pps_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .ctrl(ctrl)
  );

  pps_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .TIME_BITS(TIME_BITS)) u_dp (
    .clk(clk), .rst(rst), .in_item(in_data), .ctrl(ctrl), .stat(stat),
    .result(out_data)
  );
endmodule

[design/pps_ram.sv]
// ----------------------------------------------------------------------------
// pps_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[design/pps_datapath.sv]
// ----------------------------------------------------------------------------
// pps_datapath
// Queue memory, running slot, scan for the best entry, gap closing and timing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module pps_datapath #(
  parameter int QUEUE_DEPTH = pps_pkg::QUEUE_DEPTH,
  parameter int TIME_BITS = pps_pkg::TIME_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  pps_pkg::in_item_t in_item,
  input  pps_pkg::ctrl_t    ctrl,
  output pps_pkg::stat_t    stat,
  output pps_pkg::out_item_t result
);
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = 8 + 8 + 16 + TIME_BITS + 16;

  typedef struct packed {
    logic [7:0]           id;
    logic [7:0]           rank;
    logic [15:0]          left;
    logic [TIME_BITS-1:0] arrived;
    logic [15:0]          need;
  } entry_t;

  pps_pkg::in_item_t    req;
  logic [CW-1:0]        count;
  logic                 run_valid;
  entry_t               run;
  entry_t               prev;
  logic [TIME_BITS-1:0] now;
  logic [AW-1:0]        best;
  logic [7:0]           best_rank;
  entry_t               best_entry;
  logic [CW-1:0]        ptr;
  logic                 rd_pending;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  entry_t               wdata;
  entry_t               rdata;
  logic [CW-1:0]        ptr_idx;
  logic                 is_tick;
  logic                 better;
  logic [TIME_BITS-1:0] ct;
  logic [TIME_BITS-1:0] tat;
  logic [15:0]          left_dec;
  pps_pkg::out_item_t   result_next;

  pps_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // The scan pointer issues one read a cycle; rd_pending marks valid data.
  always_comb begin
    we = 1'b0;
    waddr = count[AW-1:0];
    wdata = '0;
    raddr = ptr[AW-1:0];
    ptr_idx = ptr - CW'(1);
    if (ctrl.arrive) begin
      we = 1'b1;
      wdata = '{req.task_id, req.priority_req, req.burst, now, req.burst};
    end else if (ctrl.shift_step && rd_pending) begin
      we = 1'b1;
      waddr = ptr_idx[AW-1:0] - AW'(1);
      wdata = rdata;
    end else if (ctrl.push_back) begin
      we = 1'b1;
      wdata = prev;
    end
  end

  assign is_tick = (req.mode == pps_pkg::MODE_TICK);
  assign better = rd_pending && (rdata.rank < best_rank || ptr_idx == '0);

  always_comb begin
    stat = '0;
    stat.mode = req.mode;
    stat.arrive_ok = (req.burst != 16'd0) && (count < CW'(QUEUE_DEPTH));
    stat.queue_empty = (count == '0);
    stat.scan_done = (ptr >= count) && !rd_pending;
    stat.take = !run_valid;
    stat.preempt = run_valid && (run.rank > best_rank);
    stat.shift_done = (ptr >= count) && !rd_pending;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      req <= in_item;
    end
    if (ctrl.scan_start) begin
      ptr <= '0;
      rd_pending <= 1'b0;
    end else if (ctrl.scan_step || ctrl.shift_step) begin
      if (ptr < count) begin
        ptr <= ptr + CW'(1);
      end
      rd_pending <= ptr < count;
    end else if (ctrl.decide) begin
      ptr <= CW'(best) + CW'(1);
      rd_pending <= 1'b0;
    end
    if (ctrl.scan_step && better) begin
      best <= ptr_idx[AW-1:0];
      best_rank <= rdata.rank;
      best_entry <= rdata;
    end
    if (ctrl.decide && is_tick && stat.preempt) begin
      prev <= run;
    end
  end

  always_comb begin
    ct = now + TIME_BITS'(1);
    tat = ct - run.arrived;
    left_dec = (run.left != 16'd0) ? run.left - 16'd1 : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      run_valid <= 1'b0;
      run <= '0;
      now <= '0;
    end else begin
      if (ctrl.arrive) begin
        count <= count + CW'(1);
      end else if (ctrl.shift_step && stat.shift_done) begin
        count <= count - CW'(1);
      end else if (ctrl.push_back) begin
        count <= count + CW'(1);
      end
      if (ctrl.decide && is_tick && (stat.take || stat.preempt)) begin
        run <= best_entry;
        run_valid <= 1'b1;
      end
      if (ctrl.finish_tick) begin
        now <= ct;
        if (run_valid) begin
          run.left <= left_dec;
          if (left_dec == 16'd0) begin
            run_valid <= 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    result_next = '0;
    if (!is_tick) begin
      result_next.dropped = !stat.arrive_ok;
    end else if (run_valid) begin
      result_next.ran_valid = 1'b1;
      result_next.ran_id = run.id;
      if (left_dec == 16'd0) begin
        result_next.finished = 1'b1;
        result_next.completion_time = 16'(ct);
        result_next.turnaround = 16'(tat);
        result_next.waiting = 16'(tat - TIME_BITS'(run.need));
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((ctrl.decide && !is_tick) || ctrl.finish_tick) begin
      result <= result_next;
    end
  end

  `ASSERT_NEVER(a_count_range, clk, rst, count > CW'(QUEUE_DEPTH), "queue count overflow")
  `ASSERT_IMPL(a_now_step, clk, rst, ctrl.finish_tick |=> now == $past(now) + TIME_BITS'(1),
               "time did not advance")
  `ASSERT_NEVER(a_push_room, clk, rst, ctrl.push_back && count >= CW'(QUEUE_DEPTH),
                "push into a full queue")
endmodule

[design/pps_ctrl.sv]
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer for arrivals and ticks: scan, decide, close gap, push back, run.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module pps_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  pps_pkg::stat_t stat,
  output pps_pkg::ctrl_t ctrl
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_SEL = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_PUSH = 3'd5;
  localparam logic [2:0] S_RUN = 3'd6;
  localparam logic [2:0] S_OUT = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       pre;
  logic       pre_next;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    ctrl = '0;
    state_next = state;
    pre_next = pre;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          ctrl.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.mode == pps_pkg::MODE_ARRIVAL) begin
          ctrl.decide = 1'b1;
          ctrl.arrive = stat.arrive_ok;
          state_next = S_OUT;
        end else if (stat.queue_empty) begin
          state_next = S_RUN;
        end else begin
          ctrl.scan_start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        ctrl.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_next = S_SEL;
        end
      end
      S_SEL: begin
        ctrl.decide = 1'b1;
        pre_next = stat.preempt;
        state_next = (stat.take || stat.preempt) ? S_SHIFT : S_RUN;
      end
      S_SHIFT: begin
        ctrl.shift_step = 1'b1;
        if (stat.shift_done) begin
          state_next = pre ? S_PUSH : S_RUN;
        end
      end
      S_PUSH: begin
        ctrl.push_back = 1'b1;
        state_next = S_RUN;
      end
      S_RUN: begin
        ctrl.finish_tick = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pre <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pre <= pre_next;
      if (state == S_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ASSERT_IMPL(a_one_result, clk, rst, (state == S_OUT) |=> out_valid, "result lost")
  `ASSERT_NEVER(a_busy_ready, clk, rst, in_ready && out_valid, "ready while result pending")
  `ASSERT_IMPL(a_push_after, clk, rst, (state == S_PUSH) |-> $past(state) == S_SHIFT,
               "push without shift")
endmodule

[dv/preemptive_priority_scheduler_core_tb.sv]
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_core_tb
// Drives arrival and tick items into the scheduler core, predicts each result
// with a cycle-free model of the ready queue and the running slot, and checks
// every result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module preemptive_priority_scheduler_core_tb;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 2 * pps_pkg::QUEUE_DEPTH + 20;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  pps_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  pps_pkg::out_item_t out_data;

  preemptive_priority_scheduler_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  logic [7:0] q_task [pps_pkg::QUEUE_DEPTH];
  logic [7:0] q_rank [pps_pkg::QUEUE_DEPTH];
  logic [15:0] q_left [pps_pkg::QUEUE_DEPTH];
  logic [15:0] q_arrived [pps_pkg::QUEUE_DEPTH];
  logic [15:0] q_need [pps_pkg::QUEUE_DEPTH];
  int q_count;
  logic run_on;
  logic [7:0] run_task;
  logic [7:0] run_rank;
  logic [15:0] run_left;
  logic [15:0] run_arrived;
  logic [15:0] run_need;
  logic [15:0] sched_time;

  pps_pkg::out_item_t expected_results[$];
  int errors;
  int idle_cycles;
  bit hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void enqueue_task(input logic [7:0] t, input logic [7:0] r,
                                       input logic [15:0] l, input logic [15:0] a,
                                       input logic [15:0] n);
    q_task[q_count] = t;
    q_rank[q_count] = r;
    q_left[q_count] = l;
    q_arrived[q_count] = a;
    q_need[q_count] = n;
    q_count++;
  endfunction

  function automatic void dispatch_entry(input int idx);
    run_task = q_task[idx];
    run_rank = q_rank[idx];
    run_left = q_left[idx];
    run_arrived = q_arrived[idx];
    run_need = q_need[idx];
    run_on = 1'b1;
    for (int i = idx; i + 1 < q_count; i++) begin
      q_task[i] = q_task[i + 1];
      q_rank[i] = q_rank[i + 1];
      q_left[i] = q_left[i + 1];
      q_arrived[i] = q_arrived[i + 1];
      q_need[i] = q_need[i + 1];
    end
    q_count--;
  endfunction

  function automatic pps_pkg::out_item_t schedule_step(input pps_pkg::in_item_t item);
    pps_pkg::out_item_t res;
    int best;
    logic [7:0] t, r;
    logic [15:0] l, a, n;
    res = '0;
    if (item.mode == pps_pkg::MODE_ARRIVAL) begin
      if (item.burst == 0 || q_count >= pps_pkg::QUEUE_DEPTH) res.dropped = 1'b1;
      else enqueue_task(item.task_id, item.priority_req, item.burst, sched_time,
                        item.burst);
      return res;
    end
    if (q_count > 0) begin
      best = 0;
      for (int i = 1; i < q_count; i++) if (q_rank[i] < q_rank[best]) best = i;
      if (!run_on) begin
        dispatch_entry(best);
      end else if (run_rank > q_rank[best]) begin
        t = run_task; r = run_rank; l = run_left; a = run_arrived; n = run_need;
        dispatch_entry(best);
        enqueue_task(t, r, l, a, n);
      end
    end
    if (run_on) begin
      res.ran_valid = 1'b1;
      res.ran_id = run_task;
      if (run_left > 0) run_left--;
      if (run_left == 0) begin
        res.finished = 1'b1;
        res.completion_time = sched_time + 16'd1;
        res.turnaround = res.completion_time - run_arrived;
        res.waiting = res.turnaround - run_need;
        run_on = 1'b0;
      end
    end
    sched_time = sched_time + 16'd1;
    return res;
  endfunction

  task automatic send_item(input pps_pkg::in_item_t item);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(schedule_step(item));
  endtask

  function automatic pps_pkg::in_item_t arrival(input logic [7:0] id,
                                                input logic [15:0] b,
                                                input logic [7:0] p);
    pps_pkg::in_item_t it;
    it.mode = pps_pkg::MODE_ARRIVAL;
    it.task_id = id;
    it.burst = b;
    it.priority_req = p;
    return it;
  endfunction

  function automatic pps_pkg::in_item_t tick_item();
    pps_pkg::in_item_t it;
    it.mode = pps_pkg::MODE_TICK;
    it.task_id = 8'($urandom);
    it.burst = 16'($urandom);
    it.priority_req = 8'($urandom);
    return it;
  endfunction

  always @(posedge clk) begin
    pps_pkg::out_item_t exp_item;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        exp_item = expected_results.pop_front();
        if (out_data.dropped !== exp_item.dropped)
          $display("%0t: dropped expected %h actual %h", $time, exp_item.dropped,
                   out_data.dropped);
        if (out_data.ran_valid !== exp_item.ran_valid)
          $display("%0t: ran_valid expected %h actual %h", $time,
                   exp_item.ran_valid, out_data.ran_valid);
        if (out_data.ran_id !== exp_item.ran_id)
          $display("%0t: ran_id expected %h actual %h", $time, exp_item.ran_id,
                   out_data.ran_id);
        if (out_data.finished !== exp_item.finished)
          $display("%0t: finished expected %h actual %h", $time,
                   exp_item.finished, out_data.finished);
        if (out_data.completion_time !== exp_item.completion_time)
          $display("%0t: completion_time expected %h actual %h", $time,
                   exp_item.completion_time, out_data.completion_time);
        if (out_data.turnaround !== exp_item.turnaround)
          $display("%0t: turnaround expected %h actual %h", $time,
                   exp_item.turnaround, out_data.turnaround);
        if (out_data.waiting !== exp_item.waiting)
          $display("%0t: waiting expected %h actual %h", $time, exp_item.waiting,
                   out_data.waiting);
        if (out_data !== exp_item) errors++;
      end
    end
  end

  initial begin
    int wait_left;
    out_ready = 1'b0;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready) begin
        wait_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
        out_ready <= (wait_left == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_extremes();
    send_item(tick_item());
    send_item(arrival(8'h00, 16'h0000, 8'h00));
    send_item(arrival(8'hff, 16'hffff, 8'hff));
    send_item(arrival(8'h01, 16'h0001, 8'h00));
    send_item(tick_item());
    send_item(tick_item());
    send_item(arrival(8'h02, 16'h0003, 8'h80));
    send_item(tick_item());
    send_item(arrival(8'h03, 16'h0001, 8'h10));
    send_item(tick_item());
    send_item(tick_item());
  endtask

  task automatic test_full_queue();
    for (int i = 0; i < pps_pkg::QUEUE_DEPTH + 2; i++)
      send_item(arrival(8'(i + 8'h20), 16'(i + 2), 8'(200 - i)));
    send_item(tick_item());
    send_item(arrival(8'h55, 16'h0002, 8'h00));
    send_item(tick_item());
  endtask

  task automatic drain_queue(input int max_items);
    int k;
    k = 0;
    while ((q_count > 0 || run_on) && k < max_items) begin
      if (run_left > 4 && $urandom_range(0, 1)) send_item(arrival(8'($urandom),
          16'($urandom_range(1, 3)), 8'h00));
      else send_item(tick_item());
      k++;
    end
  endtask

  task automatic test_random(input int n);
    pps_pkg::in_item_t it;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 40) begin
        it = arrival(8'($urandom), 16'($urandom_range(1, 6)), 8'($urandom_range(0, 7)));
        case ($urandom_range(0, 19))
          0: it.burst = 16'd0;
          1: it.burst = 16'($urandom);
          2: it.priority_req = 8'($urandom);
          default: ;
        endcase
        send_item(it);
      end else begin
        send_item(tick_item());
      end
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(40);
    join
  endtask

  initial begin
    errors = 0;
    hold_off = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    q_count = 0;
    run_on = 1'b0;
    run_task = '0;
    run_rank = '0;
    run_left = '0;
    run_arrived = '0;
    run_need = '0;
    sched_time = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_full_queue();
    drain_queue(300);
    test_backpressure();
    test_random(1400);
    drain_queue(300);
    in_valid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
